// ===== rtl/core/qpht_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadratic probe hash table package
// Table geometry, operation, status and slot mark codes, and the constants
// for the hash-modulo reduction.
// ----------------------------------------------------------------------------
`default_nettype none

package qpht_pkg;

    localparam int TABLE_SIZE = 127;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int HASH_BITS  = 31;
    localparam int FUNC_BITS  = 2;
    localparam int STAT_BITS  = 2;
    localparam int MARK_BITS  = 2;

    // Slot address width and probe counter width (the counter holds TABLE_SIZE).
    localparam int SLOT_BITS  = $clog2(TABLE_SIZE);
    localparam int PCNT_BITS  = $clog2(TABLE_SIZE + 1);
    localparam int COUNT_BITS = $clog2(TABLE_SIZE);

    // Entries allowed before a put reports a full table.
    localparam int FILL_LIMIT = TABLE_SIZE / 2;

    // Reciprocal for hash mod TABLE_SIZE: q = (hash * RECIP) >> HASH_BITS is
    // the true quotient or one less, so one conditional subtract finishes it.
    localparam longint unsigned MOD_RECIP = (longint'(1) << HASH_BITS) / TABLE_SIZE;
    localparam int RECIP_BITS = $clog2(MOD_RECIP + 1);
    localparam int PROD_BITS  = HASH_BITS + RECIP_BITS;

    // Operations
    localparam logic [FUNC_BITS-1:0] FUNC_PUT    = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_GET    = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd3;

    // Result status
    localparam logic [STAT_BITS-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_PRESENT  = 2'd2;
    localparam logic [STAT_BITS-1:0] STAT_FULL     = 2'd3;

    // Slot marks
    localparam logic [MARK_BITS-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_BITS-1:0] MARK_ACTIVE  = 2'd1;
    localparam logic [MARK_BITS-1:0] MARK_DELETED = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/quadratic_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// Quadratic probe hash table
// Open-addressed key/value store over a fixed slot array with quadratic
// probing, serving put, remove, get and clear one operation at a time.
// ----------------------------------------------------------------------------
//
//  Port group   Dir  Fields (low bit first)
//  s_axis_*     in   tuser: func[1:0]; tdata: key[31:0], hash_code[62:32],
//                    value_in[94:63], zero pad to 96
//  m_axis_*     out  tuser: status[1:0]; tdata: value_out[31:0],
//                    slot_index[38:32], zero pad to 40
//
// An operation's result word follows the hash modulo in states HASH1, HASH2
// and HASH3, then a probe of one slot per cycle (set by the single read port
// of the slot memories). A clear skips the hash and probe states and goes
// straight to ST_DONE for its result word. The next word can be taken in
// the same cycle that a result word is first presented. Reset empties the
// table at once through per-slot valid bits; no clearing pass is needed.
// A stalled output holds the finished operation, and s_axis_tready stays low
// until a new word can be taken.
`default_nettype none

module quadratic_probe_hash_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // key, hash_code, value_in, pad
    input  wire logic [95:0]                   s_axis_tdata,
    // func
    input  wire logic [qpht_pkg::FUNC_BITS-1:0] s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // value_out, slot_index, pad
    output logic [39:0]                        m_axis_tdata,
    // status
    output logic [qpht_pkg::STAT_BITS-1:0]     m_axis_tuser
);
    import qpht_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_HASH1 = 3'd1;
    localparam logic [2:0] ST_HASH2 = 3'd2;
    localparam logic [2:0] ST_HASH3 = 3'd3;
    localparam logic [2:0] ST_PROBE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // Slot memories
    logic [MARK_BITS-1:0]  mark_mem  [TABLE_SIZE];
    logic [KEY_BITS-1:0]   key_mem   [TABLE_SIZE];
    logic [VALUE_BITS-1:0] value_mem [TABLE_SIZE];

    logic [2:0]            state_reg, state_next;
    logic [FUNC_BITS-1:0]  func_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [HASH_BITS-1:0]  hash_reg;
    logic [VALUE_BITS-1:0] vin_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [HASH_BITS-1:0]  qm_reg;
    logic [SLOT_BITS-1:0]  pos_reg;
    logic [SLOT_BITS-1:0]  step_reg;
    logic [PCNT_BITS-1:0]  pcnt_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [TABLE_SIZE-1:0] valid_reg;

    logic [MARK_BITS-1:0]  mark_rd;
    logic [KEY_BITS-1:0]   key_rd;
    logic [VALUE_BITS-1:0] value_rd;
    logic                  valid_rd_reg;

    logic [STAT_BITS-1:0]  res_status_reg;
    logic [VALUE_BITS-1:0] res_value_reg;
    logic                  res_store_reg;
    logic                  res_delete_reg;
    logic                  res_clear_reg;

    logic                  m_valid_reg;
    logic [STAT_BITS-1:0]  m_status_reg;
    logic [VALUE_BITS-1:0] m_value_reg;
    logic [SLOT_BITS-1:0]  m_slot_reg;

    logic                  in_fire;
    logic                  out_free;
    logic                  finish;
    logic [SLOT_BITS-1:0]  rd_addr;
    logic [HASH_BITS-1:0]  rem_raw;
    logic [SLOT_BITS-1:0]  home_slot;
    logic [SLOT_BITS:0]    pos_sum;
    logic [SLOT_BITS-1:0]  pos_next;
    logic [SLOT_BITS:0]    step_sum;
    logic [SLOT_BITS-1:0]  step_next;
    logic [MARK_BITS-1:0]  mark_eff;
    logic                  stop;
    logic                  exhausted;
    logic                  active;
    logic [STAT_BITS-1:0]  dec_status;
    logic [VALUE_BITS-1:0] dec_value;
    logic                  dec_store;
    logic                  dec_delete;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign finish        = (state_reg == ST_DONE) && out_free;

    // Hash reduction: remainder estimate is below twice the table size.
    assign rem_raw   = hash_reg - qm_reg;
    assign home_slot = (rem_raw >= HASH_BITS'(TABLE_SIZE))
                       ? SLOT_BITS'(rem_raw - HASH_BITS'(TABLE_SIZE))
                       : SLOT_BITS'(rem_raw);

    // The i-th step is (2i-1) mod size, kept incrementally.
    assign pos_sum   = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_next  = (pos_sum >= (SLOT_BITS+1)'(TABLE_SIZE))
                       ? SLOT_BITS'(pos_sum - (SLOT_BITS+1)'(TABLE_SIZE))
                       : SLOT_BITS'(pos_sum);
    assign step_sum  = {1'b0, step_reg} + (SLOT_BITS+1)'(2);
    assign step_next = (step_sum >= (SLOT_BITS+1)'(TABLE_SIZE))
                       ? SLOT_BITS'(step_sum - (SLOT_BITS+1)'(TABLE_SIZE))
                       : SLOT_BITS'(step_sum);

    always_comb
    begin
        unique case (state_reg)
            ST_HASH3: rd_addr = home_slot;
            ST_PROBE: rd_addr = pos_next;
            default:  rd_addr = pos_reg;
        endcase
    end

    // Probe check on the word read for pos_reg in the previous cycle.
    assign mark_eff  = valid_rd_reg ? mark_rd : MARK_EMPTY;
    assign stop      = (mark_eff == MARK_EMPTY) || (key_rd == key_reg);
    assign exhausted = (pcnt_reg == PCNT_BITS'(TABLE_SIZE));
    assign active    = stop && (mark_eff == MARK_ACTIVE);

    always_comb
    begin
        dec_status = STAT_OK;
        dec_value  = '0;
        dec_store  = 1'b0;
        dec_delete = 1'b0;
        case (func_reg)
            FUNC_PUT:
            begin
                if (active)
                    dec_status = STAT_PRESENT;
                else if (!stop || count_reg >= COUNT_BITS'(FILL_LIMIT))
                    dec_status = STAT_FULL;
                else
                    dec_store = 1'b1;
            end
            FUNC_REMOVE:
            begin
                if (active)
                    dec_delete = 1'b1;
                else
                    dec_status = STAT_NOTFOUND;
            end
            FUNC_GET:
            begin
                if (active)
                    dec_value = value_rd;
                else
                    dec_status = STAT_NOTFOUND;
            end
            default:
            begin
                dec_status = STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = (s_axis_tuser == FUNC_CLEAR) ? ST_DONE : ST_HASH1;
            end
            ST_HASH1: state_next = ST_HASH2;
            ST_HASH2: state_next = ST_HASH3;
            ST_HASH3: state_next = ST_PROBE;
            ST_PROBE:
            begin
                if (stop || exhausted)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Slot memories: one read port, written when an operation completes.
    always_ff @(posedge clk)
    begin
        if (finish && res_store_reg)
        begin
            key_mem[pos_reg]   <= key_reg;
            value_mem[pos_reg] <= vin_reg;
        end
        if (finish && (res_store_reg || res_delete_reg))
            mark_mem[pos_reg] <= res_store_reg ? MARK_ACTIVE : MARK_DELETED;
        mark_rd  <= mark_mem[rd_addr];
        key_rd   <= key_mem[rd_addr];
        value_rd <= value_mem[rd_addr];
    end

    // Operation datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= s_axis_tuser;
            key_reg  <= s_axis_tdata[31:0];
            hash_reg <= s_axis_tdata[62:32];
            vin_reg  <= s_axis_tdata[94:63];
        end
        prod_reg <= PROD_BITS'(hash_reg) * PROD_BITS'(MOD_RECIP);
        qm_reg   <= HASH_BITS'(HASH_BITS'(prod_reg[HASH_BITS +: RECIP_BITS])
                    * HASH_BITS'(TABLE_SIZE));
        if (state_reg == ST_HASH3)
        begin
            pos_reg  <= home_slot;
            step_reg <= SLOT_BITS'(1);
            pcnt_reg <= PCNT_BITS'(1);
        end
        else if (state_reg == ST_PROBE)
        begin
            if (stop || exhausted)
            begin
                res_status_reg <= dec_status;
                res_value_reg  <= dec_value;
                res_store_reg  <= dec_store;
                res_delete_reg <= dec_delete;
                res_clear_reg  <= 1'b0;
            end
            else
            begin
                pos_reg  <= pos_next;
                step_reg <= step_next;
                pcnt_reg <= pcnt_reg + PCNT_BITS'(1);
            end
        end
        else if (in_fire && s_axis_tuser == FUNC_CLEAR)
        begin
            pos_reg        <= '0;
            res_status_reg <= STAT_OK;
            res_value_reg  <= '0;
            res_store_reg  <= 1'b0;
            res_delete_reg <= 1'b0;
            res_clear_reg  <= 1'b1;
        end
        if (finish)
        begin
            m_status_reg <= res_status_reg;
            m_value_reg  <= res_value_reg;
            m_slot_reg   <= pos_reg;
        end
    end

    // Control state, valid bits and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_rd_reg <= valid_reg[rd_addr];
            if (finish && res_clear_reg)
            begin
                valid_reg <= '0;
                count_reg <= '0;
            end
            else if (finish && res_store_reg)
            begin
                valid_reg[pos_reg] <= 1'b1;
                count_reg          <= count_reg + COUNT_BITS'(1);
            end
            if (finish)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {1'b0, m_slot_reg, m_value_reg};

    // Assertions
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(FILL_LIMIT))
        else $error("insert count passed the fill limit");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (pos_reg < SLOT_BITS'(TABLE_SIZE)
                                     && step_reg < SLOT_BITS'(TABLE_SIZE)))
        else $error("probe position or step out of range");

    a_probe_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (pcnt_reg != '0
                                     && pcnt_reg <= PCNT_BITS'(TABLE_SIZE)))
        else $error("probe count out of range");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word taken while an operation is in flight");

    a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[31:0] != '0) |-> (m_axis_tuser == STAT_OK))
        else $error("nonzero value returned with a failing status");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Quadratic probe hash table testbench
// Drives put, remove, get and clear words into the table over the input
// stream and checks every result word against a local model of the slot
// store or, for typed rows, the row itself. A short table of directed words
// comes first, then random words drawn mostly from a fixed pool of keys
// with crowded home slots, across three idle patterns on both stream sides.
// ----------------------------------------------------------------------------

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import qpht_pkg::*;

    localparam int POOL_SIZE        = 96;
    localparam int RANDOM_PER_PHASE = 560;
    localparam int QUIET_LIMIT      = 4000;
    // Longest operation is a probe of every slot plus the fixed pipeline.
    localparam int TAIL_CYCLES      = TABLE_SIZE + 16;
    localparam int REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [STAT_BITS-1:0]  status;
        logic [31:0]           value_out;
        logic [SLOT_BITS-1:0]  slot_index;
    } op_result_t;

    typedef struct packed {
        logic [FUNC_BITS-1:0]  func;
        logic [KEY_BITS-1:0]   key;
        logic [HASH_BITS-1:0]  hash_code;
        logic [VALUE_BITS-1:0] value_in;
        bit                    typed;
        op_result_t            want;
    } table_row_t;

    localparam op_result_t UNTYPED = '0;
    localparam int DIRECTED_ROWS = 21;

    // Rows with typed set carry a result that is plain from the row itself;
    // the others are checked against the slot model.
    table_row_t directed_rows [DIRECTED_ROWS] = '{
        '{FUNC_GET,    32'h0000_0000, 31'h0000_0000, 32'h0000_0000, 1'b1,
          '{STAT_NOTFOUND, 32'h0000_0000, 7'd0}},
        '{FUNC_REMOVE, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{STAT_NOTFOUND, 32'h0000_0000, 7'd7}},
        '{FUNC_PUT,    32'h0000_0000, 31'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{STAT_OK, 32'h0000_0000, 7'd0}},
        '{FUNC_PUT,    32'h0000_0000, 31'h0000_0000, 32'h0000_1234, 1'b1,
          '{STAT_PRESENT, 32'h0000_0000, 7'd0}},
        '{FUNC_GET,    32'h0000_0000, 31'h0000_0000, 32'h0000_0000, 1'b1,
          '{STAT_OK, 32'hFFFF_FFFF, 7'd0}},
        '{FUNC_PUT,    32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0000_0000, 1'b1,
          '{STAT_OK, 32'h0000_0000, 7'd7}},
        '{FUNC_GET,    32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{STAT_OK, 32'h0000_0000, 7'd7}},
        // Collisions on home slot zero, then a chain that crosses a deleted slot.
        '{FUNC_PUT,    32'h0000_0005, 31'h0000_0000, 32'hA5A5_A5A5, 1'b0, UNTYPED},
        '{FUNC_PUT,    32'h0000_0006, 31'h0000_007F, 32'h5A5A_5A5A, 1'b0, UNTYPED},
        '{FUNC_GET,    32'h0000_0006, 31'h0000_007F, 32'h0000_0000, 1'b0, UNTYPED},
        '{FUNC_REMOVE, 32'h0000_0005, 31'h0000_0000, 32'h0000_0000, 1'b0, UNTYPED},
        '{FUNC_REMOVE, 32'h0000_0005, 31'h0000_0000, 32'h0000_0000, 1'b0, UNTYPED},
        '{FUNC_GET,    32'h0000_0005, 31'h0000_0000, 32'h0000_0000, 1'b0, UNTYPED},
        '{FUNC_GET,    32'h0000_0006, 31'h0000_007F, 32'h0000_0000, 1'b0, UNTYPED},
        '{FUNC_PUT,    32'h0000_0005, 31'h0000_0000, 32'h0000_0001, 1'b0, UNTYPED},
        '{FUNC_GET,    32'h0000_0000, 31'h0000_0001, 32'h0000_0000, 1'b0, UNTYPED},
        '{FUNC_REMOVE, 32'h0000_0000, 31'h0000_0000, 32'h0000_0000, 1'b0, UNTYPED},
        '{FUNC_PUT,    32'h0000_0000, 31'h0000_00FE, 32'h0000_0002, 1'b0, UNTYPED},
        '{FUNC_CLEAR,  32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{STAT_OK, 32'h0000_0000, 7'd0}},
        '{FUNC_GET,    32'h0000_0000, 31'h0000_0000, 32'h0000_0000, 1'b1,
          '{STAT_NOTFOUND, 32'h0000_0000, 7'd0}},
        '{FUNC_PUT,    32'h8000_0000, 31'h4000_0000, 32'h8000_0000, 1'b0, UNTYPED}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [95:0]           s_axis_tdata = '0;
    logic [FUNC_BITS-1:0]  s_axis_tuser = FUNC_PUT;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;
    logic [STAT_BITS-1:0]  m_axis_tuser;

    // Local copy of the slot store.
    logic [MARK_BITS-1:0]  slot_marks  [TABLE_SIZE];
    logic [KEY_BITS-1:0]   slot_keys   [TABLE_SIZE];
    logic [VALUE_BITS-1:0] slot_values [TABLE_SIZE];
    int                    stored_count;

    logic [KEY_BITS-1:0]   pool_keys   [POOL_SIZE];
    logic [HASH_BITS-1:0]  pool_hashes [POOL_SIZE];

    op_result_t            pending_results [$];
    op_result_t            seen_result;
    op_result_t            oldest_result;
    int                    mismatches = 0;
    int                    quiet_cycles = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;

    quadratic_probe_hash_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Walks the quadratic sequence until an empty slot or an equal key.
    function automatic logic [SLOT_BITS-1:0] probe_stop_slot(
        input logic [KEY_BITS-1:0] k, input logic [HASH_BITS-1:0] h, output bit hit);
        int unsigned pos;
        int unsigned n;
        pos = int'(h) % TABLE_SIZE;
        hit = 1'b0;
        for (n = 1; n <= TABLE_SIZE; n++)
        begin
            if (slot_marks[pos] == MARK_EMPTY || slot_keys[pos] == k)
            begin
                hit = 1'b1;
                return pos[SLOT_BITS-1:0];
            end
            if (n == TABLE_SIZE)
                break;
            pos = (pos + 2 * n - 1) % TABLE_SIZE;
        end
        return pos[SLOT_BITS-1:0];
    endfunction

    function automatic op_result_t apply_table_op(
        input logic [FUNC_BITS-1:0] f, input logic [KEY_BITS-1:0] k,
        input logic [HASH_BITS-1:0] h, input logic [VALUE_BITS-1:0] v);
        op_result_t res;
        bit         hit;
        bit         active;
        res = '{STAT_OK, 32'h0, '0};
        if (f == FUNC_CLEAR)
        begin
            foreach (slot_marks[i])
                slot_marks[i] = MARK_EMPTY;
            stored_count = 0;
        end
        else
        begin
            res.slot_index = probe_stop_slot(k, h, hit);
            active = hit && slot_marks[res.slot_index] == MARK_ACTIVE;
            if (f == FUNC_PUT)
            begin
                if (active)
                    res.status = STAT_PRESENT;
                else if (!hit || stored_count >= FILL_LIMIT)
                    res.status = STAT_FULL;
                else
                begin
                    slot_keys[res.slot_index]   = k;
                    slot_values[res.slot_index] = v;
                    slot_marks[res.slot_index]  = MARK_ACTIVE;
                    stored_count++;
                end
            end
            else if (f == FUNC_REMOVE)
            begin
                if (active)
                    slot_marks[res.slot_index] = MARK_DELETED;
                else
                    res.status = STAT_NOTFOUND;
            end
            else if (active)
                res.value_out = slot_values[res.slot_index];
            else
                res.status = STAT_NOTFOUND;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Presents one word, waits for its handshake and records what it should return.
    task automatic send_op(input logic [FUNC_BITS-1:0] f, input logic [KEY_BITS-1:0] k,
        input logic [HASH_BITS-1:0] h, input logic [VALUE_BITS-1:0] v,
        input bit typed, input op_result_t want);
        op_result_t modeled;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tuser  = f;
        s_axis_tdata  = {1'b0, v, h, k};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        modeled = apply_table_op(f, k, h, v);
        pending_results.push_back(typed ? want : modeled);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Mostly pool keys with their own hash; a few words carry arbitrary fields.
    task automatic random_op(output logic [FUNC_BITS-1:0] f, output logic [KEY_BITS-1:0] k,
        output logic [HASH_BITS-1:0] h, output logic [VALUE_BITS-1:0] v);
        int pick;
        int r;
        r = $urandom_range(999);
        v = $urandom;
        if (r < 80)
        begin
            f = FUNC_BITS'($urandom_range(int'(FUNC_GET)));
            k = $urandom;
            h = HASH_BITS'($urandom);
        end
        else
        begin
            pick = $urandom_range(POOL_SIZE - 1);
            k = pool_keys[pick];
            h = pool_hashes[pick];
            // Clears are rare so the fill count reaches the full-table limit.
            if (r < 85)
                f = FUNC_CLEAR;
            else if (r < 500)
                f = FUNC_PUT;
            else if (r < 680)
                f = FUNC_REMOVE;
            else
                f = FUNC_GET;
        end
    endtask

    initial
    begin : stimulus
        logic [FUNC_BITS-1:0]  f;
        logic [KEY_BITS-1:0]   k;
        logic [HASH_BITS-1:0]  h;
        logic [VALUE_BITS-1:0] v;
        int                    phase;
        int                    i;
        foreach (slot_marks[j])
            slot_marks[j] = MARK_EMPTY;
        stored_count = 0;
        // Half the pool crowds onto four home slots to force long probe chains.
        foreach (pool_keys[j])
        begin
            pool_keys[j] = $urandom;
            if (j % 2 == 0)
                pool_hashes[j] = HASH_BITS'($urandom_range(16900000) * TABLE_SIZE
                                            + $urandom_range(3));
            else
                pool_hashes[j] = HASH_BITS'($urandom);
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 19 : 0;
            if (phase == 0)
                foreach (directed_rows[j])
                    send_op(directed_rows[j].func, directed_rows[j].key,
                            directed_rows[j].hash_code, directed_rows[j].value_in,
                            directed_rows[j].typed, directed_rows[j].want);
            for (i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if ($urandom_range(199) == 0)
                    drain_results();
                random_op(f, k, h, v);
                send_op(f, k, h, v, 1'b0, UNTYPED);
            end
            drain_results();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS quadratic_probe_hash_table");
        else
            $display("FAIL quadratic_probe_hash_table");
        $finish;
    end

    always @(negedge clk)
        m_axis_tready = rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_result = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[38:32]};
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected word status %0d value %h slot %0d",
                    seen_result.status, seen_result.value_out, seen_result.slot_index));
            else
            begin
                oldest_result = pending_results.pop_front();
                if (seen_result.status !== oldest_result.status
                    || seen_result.value_out !== oldest_result.value_out
                    || seen_result.slot_index !== oldest_result.slot_index)
                    report_mismatch($sformatf(
                        "expected status %0d value %h slot %0d, got status %0d value %h slot %0d",
                        oldest_result.status, oldest_result.value_out, oldest_result.slot_index,
                        seen_result.status, seen_result.value_out, seen_result.slot_index));
            end
        end
    end

    // Ends the run when neither side has moved a word for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL quadratic_probe_hash_table");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
rtl/core/qpht_pkg.sv
rtl/core/quadratic_probe_hash_table.sv
tb/tb_top.sv
